>>> src/lprks_pkg.sv
package lprks_pkg;

  localparam int MAX_KEY_BYTES    = 32;
  localparam int REGION_ADDR_BITS = 20;
  localparam int HDR_BYTES        = 8;

  localparam int OFS_W     = REGION_ADDR_BITS + 1;
  localparam int KLEN_W    = 6;
  localparam int KIDX_W    = $clog2(MAX_KEY_BYTES);
  localparam int FCNT_W    = 6;
  localparam int LEN_W     = 32;
  localparam int SUM_W     = 34;
  localparam int NEXT_W    = SUM_W + 1;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int KEY_WORDS = 4;
  localparam int BYTES_PER_WORD = 8;

  localparam logic [KLEN_W-1:0] KLEN_MAX     = KLEN_W'(MAX_KEY_BYTES);
  localparam logic [KLEN_W-1:0] KLEN_RESET   = KLEN_W'(8);
  localparam logic [OFS_W-1:0]  REGION_LIMIT = OFS_W'(1) << REGION_ADDR_BITS;
  localparam logic [FCNT_W-1:0] HDR_LAST     = FCNT_W'(HDR_BYTES - 1);
  localparam logic [FCNT_W-1:0] HDR_LEN      = FCNT_W'(HDR_BYTES);

  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_SIZE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3  = 3'd5;

  typedef struct packed {
    logic       first;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic                        found;
    logic [REGION_ADDR_BITS-1:0] record_offset;
  } result_t;

  typedef struct packed {
    logic                  wen;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

>>> src/lprks_fifo.sv
module lprks_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lprks_pkg::item_t push_item,
  output logic           not_full,
  input  logic           pop,
  output logic           not_empty,
  output lprks_pkg::item_t head_item
);
  import lprks_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  item_t              mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     count;

  assign not_full  = count != (PTR_W+1)'(DEPTH);
  assign not_empty = count != '0;
  assign head_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      if (push && !pop) begin
        count <= count + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_W+1)'(1);
      end
    end
  end

endmodule

>>> src/lprks_scan.sv
module lprks_scan (
  input  logic               clk,
  input  logic               rst,
  input  lprks_pkg::cfg_wr_t cfg,
  input  logic               in_valid,
  input  lprks_pkg::item_t   in_item,
  output logic               in_pop,
  output logic               out_valid,
  output lprks_pkg::result_t out_result,
  input  logic               out_ready
);
  import lprks_pkg::*;

  typedef enum logic [1:0] {PH_DONE, PH_READ, PH_SKIP} phase_t;

  logic [KLEN_W-1:0]           key_length;
  logic [OFS_W-1:0]            region_size;
  logic [7:0]                  key_mem [MAX_KEY_BYTES];

  phase_t                      phase, phase_next;
  logic [OFS_W-1:0]            byte_off, byte_off_next;
  logic [REGION_ADDR_BITS-1:0] rec_start, rec_start_next;
  logic [FCNT_W-1:0]           fcnt, fcnt_next;
  logic [LEN_W-1:0]            rk_len, rk_len_next;
  logic [LEN_W-1:0]            rv_len, rv_len_next;
  logic                        mism, mism_next;
  logic [SUM_W-1:0]            sum_a, sum_a_next;
  logic                        emit;
  result_t                     emit_result;

  logic [KLEN_W-1:0]           klen_eff;
  logic [OFS_W-1:0]            region_eff;
  logic                        bound0;
  logic [OFS_W-1:0]            byte_off_inc;
  logic                        fresh;
  logic                        do_rec;
  logic [FCNT_W-1:0]           p;
  logic [FCNT_W-1:0]           pk;
  logic [LEN_W-1:0]            rk_cur, rv_cur;
  logic [REGION_ADDR_BITS-1:0] start_cur;
  logic [7:0]                  b;
  logic [KLEN_W-1:0]           cmpsz;
  logic                        decide;
  logic [LEN_W-1:0]            val_full;
  logic [NEXT_W-1:0]           next_bound;
  logic [NEXT_W-1:0]           next_start;
  logic                        next_ok;

  assign in_pop = in_valid && (!out_valid || out_ready);
  assign b      = in_item.data_byte;

  assign klen_eff   = (key_length > KLEN_MAX) ? KLEN_MAX : key_length;
  assign region_eff = (region_size > REGION_LIMIT) ? REGION_LIMIT : region_size;
  assign bound0     = (OFS_W'(HDR_BYTES) + OFS_W'(klen_eff)) < region_eff;
  assign byte_off_inc = (&byte_off) ? byte_off : byte_off + OFS_W'(1);

  assign cmpsz = (rk_len[LEN_W-1:KLEN_W] != '0 || rk_len[KLEN_W-1:0] > klen_eff)
               ? klen_eff : rk_len[KLEN_W-1:0];

  always_comb begin
    fresh = in_item.first
         || (phase == PH_SKIP && byte_off_inc == OFS_W'(rec_start));
    do_rec = in_item.first ? bound0 : (phase == PH_READ ||
             (phase == PH_SKIP && byte_off_inc == OFS_W'(rec_start)));
    p         = fresh ? '0 : fcnt;
    rk_cur    = fresh ? '0 : rk_len;
    rv_cur    = fresh ? '0 : rv_len;
    start_cur = in_item.first ? '0 : rec_start;
    pk        = p - HDR_LEN;
    val_full  = (p == HDR_LAST) ? {b, rv_len[23:0]} : rv_len;
    next_start = NEXT_W'(sum_a) + NEXT_W'(val_full);
    next_bound = next_start + NEXT_W'(HDR_BYTES) + NEXT_W'(klen_eff);
    next_ok    = next_bound < NEXT_W'(region_eff);
    decide     = (p >= HDR_LAST) && ((p - HDR_LAST) == cmpsz);

    phase_next     = phase;
    byte_off_next  = byte_off;
    rec_start_next = rec_start;
    fcnt_next      = fcnt;
    rk_len_next    = rk_len;
    rv_len_next    = rv_len;
    mism_next      = mism;
    sum_a_next     = sum_a;
    emit           = 1'b0;
    emit_result    = '0;

    if (in_item.first) begin
      byte_off_next  = '0;
      rec_start_next = '0;
      fcnt_next      = '0;
      rk_len_next    = '0;
      rv_len_next    = '0;
      mism_next      = 1'b0;
      if (!bound0) begin
        emit       = 1'b1;
        phase_next = PH_DONE;
      end
    end else if (phase != PH_DONE) begin
      byte_off_next = byte_off_inc;
    end

    if (do_rec) begin
      rk_len_next = rk_cur;
      rv_len_next = rv_cur;
      mism_next   = fresh ? 1'b0 : mism;
      if (p < FCNT_W'(4)) begin
        rk_len_next[8*p[1:0] +: 8] = b;
      end else if (p < HDR_LEN) begin
        rv_len_next[8*p[1:0] +: 8] = b;
      end else if (key_mem[pk[KIDX_W-1:0]] != b) begin
        mism_next = 1'b1;
      end
      if (p == FCNT_W'(3)) begin
        sum_a_next = SUM_W'(start_cur) + SUM_W'(HDR_BYTES) + SUM_W'(rk_len_next);
      end
      fcnt_next  = p + FCNT_W'(1);
      phase_next = PH_READ;
      if (decide) begin
        if (!mism_next) begin
          emit                      = 1'b1;
          emit_result.found         = 1'b1;
          emit_result.record_offset = start_cur;
          phase_next                = PH_DONE;
        end else if (!next_ok) begin
          emit       = 1'b1;
          phase_next = PH_DONE;
        end else begin
          rec_start_next = next_start[REGION_ADDR_BITS-1:0];
          phase_next     = PH_SKIP;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length  <= KLEN_RESET;
      region_size <= '0;
      for (int i = 0; i < MAX_KEY_BYTES; i++) begin
        key_mem[i] <= '0;
      end
    end else if (cfg.wen) begin
      unique case (cfg.index)
        REG_KEY_LENGTH:  key_length  <= cfg.data[KLEN_W-1:0];
        REG_REGION_SIZE: region_size <= cfg.data[OFS_W-1:0];
        REG_KEY_WORD_0, REG_KEY_WORD_1, REG_KEY_WORD_2, REG_KEY_WORD_3: begin
          for (int j = 0; j < BYTES_PER_WORD; j++) begin
            key_mem[KIDX_W'(int'(cfg.index - REG_KEY_WORD_0) * BYTES_PER_WORD + j)]
              <= cfg.data[8*j +: 8];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_DONE;
      byte_off  <= '0;
      rec_start <= '0;
      fcnt      <= '0;
      rk_len    <= '0;
      rv_len    <= '0;
      mism      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_pop) begin
        phase     <= phase_next;
        byte_off  <= byte_off_next;
        rec_start <= rec_start_next;
        fcnt      <= fcnt_next;
        rk_len    <= rk_len_next;
        rv_len    <= rv_len_next;
        mism      <= mism_next;
      end
      if (in_pop && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_pop) begin
      sum_a <= sum_a_next;
      if (emit) out_result <= emit_result;
    end
  end

endmodule

>>> src/length_prefixed_record_key_scan_core.sv
// A result is offered on m_tvalid once the byte that decides it has been written
// into the queue, popped by the scan stage and registered into the output valid.
// Throughput: one byte per cycle; the scan stage waits only while a result
// is held and not yet taken. A four-entry queue decouples input and scan.
// Reset (rst, synchronous): queue empty, no scan running, registers at defaults.
module length_prefixed_record_key_scan_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,   // data_byte
  input  logic                               s_tuser,   // first
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [23:0]                        m_tdata,   // record_offset[19:0], zero pad
  output logic                               m_tuser,   // found
  input  logic                               cfg_wen,
  input  logic [lprks_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lprks_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lprks_pkg::*;

  item_t   in_item;
  item_t   head_item;
  logic    head_valid;
  logic    head_pop;
  cfg_wr_t cfg;
  result_t result;

  assign in_item.data_byte = s_tdata;
  assign in_item.first     = s_tuser;

  assign cfg.wen   = cfg_wen;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  lprks_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid && s_tready),
    .push_item (in_item),
    .not_full  (s_tready),
    .pop       (head_pop),
    .not_empty (head_valid),
    .head_item (head_item)
  );

  lprks_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (head_valid),
    .in_item    (head_item),
    .in_pop     (head_pop),
    .out_valid  (m_tvalid),
    .out_result (result),
    .out_ready  (m_tready)
  );

  assign m_tdata = {(24 - REGION_ADDR_BITS)'(0), result.record_offset};
  assign m_tuser = result.found;

endmodule
